// ----- rtl/mse_pkg.sv -----
// Types and constants shared by the merge sort engine.
package mse_pkg;

  localparam int unsigned ValueWidth = 64;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         final_res;
    logic                         overflow;
  } out_item_t;

endpackage

// ----- rtl/merge_sort_engine.sv -----
// Merge sort engine: collects a list, sorts it by bottom-up merge passes, emits it in order.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one signed value per transfer,
// the transfer with last set closes the list. Values beyond MAX_ITEMS are dropped and
// every result of that list then carries overflow.
// Output channel (out_valid_o / out_stall_i / out_data_o): the values in ascending
// order, final_res set on the last one.
// Loading accepts one transfer per cycle while idle. Sorting runs ceil(log2 n) passes
// between two ping-pong memories; in each pass every merged block starts with a
// set-up step, then each element is read and then compared and written back.
// Emitting reads each element from memory, then loads it into the output register.
// in_stall_o is high from the closing transfer until the last result has been
// loaded into the output register, so the next list can load while that result waits.
// A stalled result holds in the output register; emission pauses until it is taken.
// Reset empties the list and drops any pending result; memory contents are not cleared.
module merge_sort_engine #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mse_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mse_pkg::out_item_t  out_data_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned PW = CW + 2;
  localparam int unsigned VW = mse_pkg::ValueWidth;
  localparam logic [PW-1:0] Max = PW'(MAX_ITEMS);
  localparam logic [PW-1:0] One = PW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RD,
    S_CMP,
    S_ERD,
    S_EWAIT
  } state_e;

  state_e          state_q;
  logic [PW-1:0]   count_q, n_q, lo_q, mid_q, hi_q, i_q, j_q, k_q, wid_q, e_q;
  logic            ovf_q, list_ovf_q, src_q;
  logic            out_valid_q;
  mse_pkg::out_item_t out_q;

  logic [VW-1:0]   mem_a [MAX_ITEMS];
  logic [VW-1:0]   mem_b [MAX_ITEMS];
  logic [VW-1:0]   rd_a0_q, rd_a1_q, rd_b0_q, rd_b1_q;

  logic [AW-1:0]   rd0_addr, rd1_addr, wr_addr;
  logic            we_a, we_b;
  logic [VW-1:0]   wr_data;
  logic [VW-1:0]   head_i, head_j;
  logic            take_left;
  logic            in_fire;
  logic            out_free;
  logic [PW-1:0]   lo_w, lo_2w, nlo, nwid;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign head_i    = src_q ? rd_b0_q : rd_a0_q;
  assign head_j    = src_q ? rd_b1_q : rd_a1_q;
  assign take_left = (i_q < mid_q) &&
                     ((j_q >= hi_q) || ($signed(head_i) < $signed(head_j)));

  assign lo_w  = lo_q + wid_q;
  assign lo_2w = lo_q + (wid_q << 1);
  assign nlo   = lo_2w;
  assign nwid  = wid_q << 1;

  assign rd0_addr = ((state_q == S_ERD) || (state_q == S_EWAIT)) ? e_q[AW-1:0] : i_q[AW-1:0];
  assign rd1_addr = j_q[AW-1:0];

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    wr_addr = k_q[AW-1:0];
    wr_data = take_left ? head_i : head_j;
    if (in_fire) begin
      we_a    = (count_q < Max);
      wr_addr = count_q[AW-1:0];
      wr_data = in_data_i.value;
    end else if (state_q == S_CMP) begin
      we_a = src_q;
      we_b = !src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a0_q <= mem_a[rd0_addr];
    rd_a1_q <= mem_a[rd1_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b0_q <= mem_b[rd0_addr];
    rd_b1_q <= mem_b[rd1_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      n_q         <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      wid_q       <= '0;
      e_q         <= '0;
      ovf_q       <= 1'b0;
      list_ovf_q  <= 1'b0;
      src_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_EWAIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_data_i.last) begin
              n_q        <= (count_q < Max) ? count_q + One : count_q;
              list_ovf_q <= ovf_q || (count_q >= Max);
              count_q    <= '0;
              ovf_q      <= 1'b0;
              src_q      <= 1'b0;
              lo_q       <= '0;
              wid_q      <= One;
              e_q        <= '0;
              state_q    <= ((count_q == '0) || (count_q >= Max && Max == One)) ?
                            S_ERD : S_SETUP;
            end else if (count_q < Max) begin
              count_q <= count_q + One;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        S_SETUP: begin
          mid_q   <= (lo_w < n_q) ? lo_w : n_q;
          hi_q    <= (lo_2w < n_q) ? lo_2w : n_q;
          i_q     <= lo_q;
          j_q     <= (lo_w < n_q) ? lo_w : n_q;
          k_q     <= lo_q;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          k_q <= k_q + One;
          if (take_left) begin
            i_q <= i_q + One;
          end else begin
            j_q <= j_q + One;
          end
          if (k_q + One == hi_q) begin
            if (nlo >= n_q) begin
              src_q <= !src_q;
              wid_q <= nwid;
              lo_q  <= '0;
              if (nwid >= n_q) begin
                e_q     <= '0;
                state_q <= S_ERD;
              end else begin
                state_q <= S_SETUP;
              end
            end else begin
              lo_q    <= nlo;
              state_q <= S_SETUP;
            end
          end else begin
            state_q <= S_RD;
          end
        end
        S_ERD: begin
          state_q <= S_EWAIT;
        end
        S_EWAIT: begin
          if (out_free) begin
            out_valid_q        <= 1'b1;
            out_q.sorted_value <= src_q ? rd_b0_q : rd_a0_q;
            out_q.final_res    <= (e_q + One == n_q);
            out_q.overflow     <= list_ovf_q;
            if (e_q + One == n_q) begin
              state_q <= S_IDLE;
            end else begin
              e_q     <= e_q + One;
              state_q <= S_ERD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Max)
    else $error("fill count beyond capacity");

  a_merge_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ((i_q < mid_q) || (j_q < hi_q)))
    else $error("merge step with both runs exhausted");

  a_merge_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> ((i_q - lo_q) + (j_q - mid_q) == (k_q - lo_q)))
    else $error("merge write index out of step with run indices");

  a_load_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EWAIT))
    else $error("result loaded outside emit");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EWAIT && out_free && (e_q + One == n_q)) |=>
      (state_q == S_IDLE && out_q.final_res))
    else $error("final result without return to idle");

endmodule
